FILE: rtl/mbrm_pkg.sv
// Shared types and constants for the multi-bank buffer ring manager.
// Used by mbrm_ctrl, mbrm_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mbrm_pkg;

  localparam int NUM_BANKS  = 4;
  localparam int BANK_BYTES = 65536;

  localparam int BANK_W  = 2;
  localparam int LEVEL_W = 17;
  localparam int TAIL_W  = 19;
  localparam int RING_W  = 3;

  // Command codes.
  localparam logic [2:0] CMD_WRITE       = 3'd0;
  localparam logic [2:0] CMD_BEGIN_READ  = 3'd1;
  localparam logic [2:0] CMD_FINISH_READ = 3'd2;
  localparam logic [2:0] CMD_QUERY       = 3'd3;
  localparam logic [2:0] CMD_TAIL        = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NOTHING  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OVERWRITE = 2'd0;
  localparam logic [1:0] CFG_BANKS     = 2'd1;
  localparam logic [1:0] CFG_CAPACITY  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [LEVEL_W-1:0] chunk_length;
    logic [BANK_W-1:0]  bank_select;
    logic [TAIL_W-1:0]  tail_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BANK_W-1:0]  bank;
    logic [LEVEL_W-1:0] offset;
    logic [LEVEL_W-1:0] length_out;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_WR,
    OP_LOAD_RD,
    OP_LOAD_FIN,
    OP_LOAD_QRY,
    OP_LOAD_TAIL,
    OP_BAD,
    OP_WR_CHECK,
    OP_WR_NEXT,
    OP_RD_STEP,
    OP_FIN,
    OP_QRY,
    OP_TAIL_STEP,
    OP_TAIL_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_adv;
    logic rd_done;
    logic tail_stop;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/mbrm_ctrl.sv
// Controller state machine of the bank ring manager.
// Sequences one command at a time; depends on mbrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [2:0]          command,
  input  wire mbrm_pkg::dp_status_t sts,
  output mbrm_pkg::dp_cmd_t        cmd,
  output logic                     busy
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_WR_CHECK = 8'b0000_0010,
    S_WR_NEXT  = 8'b0000_0100,
    S_RD_SCAN  = 8'b0000_1000,
    S_FIN      = 8'b0001_0000,
    S_QRY      = 8'b0010_0000,
    S_TAIL     = 8'b0100_0000,
    S_TAIL_END = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = mbrm_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            mbrm_pkg::CMD_WRITE: begin
              cmd.op     = mbrm_pkg::OP_LOAD_WR;
              state_next = S_WR_CHECK;
            end
            mbrm_pkg::CMD_BEGIN_READ: begin
              cmd.op     = mbrm_pkg::OP_LOAD_RD;
              state_next = S_RD_SCAN;
            end
            mbrm_pkg::CMD_FINISH_READ: begin
              cmd.op     = mbrm_pkg::OP_LOAD_FIN;
              state_next = S_FIN;
            end
            mbrm_pkg::CMD_QUERY: begin
              cmd.op     = mbrm_pkg::OP_LOAD_QRY;
              state_next = S_QRY;
            end
            mbrm_pkg::CMD_TAIL: begin
              cmd.op     = mbrm_pkg::OP_LOAD_TAIL;
              state_next = S_TAIL;
            end
            default: begin
              // An unknown command is answered at once and leaves the block idle.
              cmd.op = mbrm_pkg::OP_BAD;
            end
          endcase
        end
      end
      S_WR_CHECK: begin
        cmd.op     = mbrm_pkg::OP_WR_CHECK;
        state_next = sts.need_adv ? S_WR_NEXT : S_IDLE;
      end
      S_WR_NEXT: begin
        cmd.op     = mbrm_pkg::OP_WR_NEXT;
        state_next = S_IDLE;
      end
      S_RD_SCAN: begin
        cmd.op = mbrm_pkg::OP_RD_STEP;
        if (sts.rd_done) begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        cmd.op     = mbrm_pkg::OP_FIN;
        state_next = S_IDLE;
      end
      S_QRY: begin
        cmd.op     = mbrm_pkg::OP_QRY;
        state_next = S_IDLE;
      end
      S_TAIL: begin
        cmd.op = mbrm_pkg::OP_TAIL_STEP;
        if (sts.tail_stop) begin
          state_next = S_TAIL_END;
        end
      end
      S_TAIL_END: begin
        cmd.op     = mbrm_pkg::OP_TAIL_END;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mbrm_dp.sv
// Datapath of the bank ring manager: configuration, bank levels and marks,
// ring pointers, the access pointer and the result register. Uses mbrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrm_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mbrm_pkg::in_item_t   item,
  input  wire mbrm_pkg::dp_cmd_t    cmd,
  output mbrm_pkg::dp_status_t      sts,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [mbrm_pkg::LEVEL_W-1:0] cfg_data,
  output mbrm_pkg::result_t         result,
  output logic                      result_valid
);

  localparam int BW = mbrm_pkg::BANK_W;
  localparam int LW = mbrm_pkg::LEVEL_W;
  localparam int TW = mbrm_pkg::TAIL_W;
  localparam int RW = mbrm_pkg::RING_W;

  // Configuration registers.
  logic          overwrite_mode;
  logic [RW-1:0] banks_in_use;
  logic [LW-1:0] bank_capacity;

  // Ring state.
  logic [LW-1:0] fill_level [mbrm_pkg::NUM_BANKS];
  logic          bank_full  [mbrm_pkg::NUM_BANKS];
  logic [BW-1:0] write_bank;
  logic [BW-1:0] read_bank;

  // Working registers of the current command.
  logic [BW-1:0]     ptr;
  logic [BW-1:0]     cnt;
  logic [LW-1:0]     chunk_len;
  logic [TW-1:0]     want;
  mbrm_pkg::result_t pend;
  logic              pend_valid;

  logic [RW-1:0] ring_n;
  logic [LW-1:0] cap;
  logic [BW-1:0] wb_red, rb_red, ptr_next, ptr_prev;
  logic [LW-1:0] fill_cur;
  logic          full_cur;
  logic [LW:0]   sum;
  logic          fits, too_long, cnt_last;
  logic [LW-1:0] take;
  logic [TW-1:0] want_after;
  logic          res_fire;

  function automatic logic [BW-1:0] reduce(input logic [BW-1:0] idx,
                                           input logic [RW-1:0] n);
    logic [RW-1:0] wide;
    wide = {1'b0, idx};
    return (wide >= n) ? BW'(wide - n) : idx;
  endfunction

  function automatic mbrm_pkg::result_t make_res(input logic [1:0]    st,
                                                 input logic [BW-1:0] bk,
                                                 input logic [LW-1:0] off,
                                                 input logic [LW-1:0] len,
                                                 input logic          lst);
    mbrm_pkg::result_t r;
    r.status     = st;
    r.bank       = bk;
    r.offset     = off;
    r.length_out = len;
    r.last       = lst;
    return r;
  endfunction

  always_comb begin
    if (banks_in_use < RW'(2)) begin
      ring_n = RW'(2);
    end else if (banks_in_use > RW'(mbrm_pkg::NUM_BANKS)) begin
      ring_n = RW'(mbrm_pkg::NUM_BANKS);
    end else begin
      ring_n = banks_in_use;
    end

    if (bank_capacity == '0) begin
      cap = LW'(1);
    end else if (bank_capacity > LW'(mbrm_pkg::BANK_BYTES)) begin
      cap = LW'(mbrm_pkg::BANK_BYTES);
    end else begin
      cap = bank_capacity;
    end
  end

  assign wb_red   = reduce(write_bank, ring_n);
  assign rb_red   = reduce(read_bank, ring_n);
  assign ptr_next = ({1'b0, ptr} + RW'(1) == ring_n) ? '0 : BW'(ptr + BW'(1));
  assign ptr_prev = (ptr == '0) ? BW'(ring_n - RW'(1)) : BW'(ptr - BW'(1));
  assign cnt_last = ({1'b0, cnt} == ring_n - RW'(1));

  assign fill_cur = fill_level[ptr];
  assign full_cur = bank_full[ptr];
  assign sum      = {1'b0, fill_cur} + {1'b0, chunk_len};
  assign fits     = (sum <= {1'b0, cap});
  assign too_long = (chunk_len > cap);

  // The tail piece takes the whole bank unless fewer bytes are still wanted.
  assign take       = ({2'b00, fill_cur} > want) ? LW'(want) : fill_cur;
  assign want_after = (fill_cur != '0) ? want - {2'b00, take} : want;

  assign sts.need_adv  = !too_long && !fits && (overwrite_mode || !full_cur);
  assign sts.rd_done   = full_cur || cnt_last;
  assign sts.tail_stop = cnt_last || (ptr_prev == rb_red) || (want_after == '0);

  // A result leaves in every step that finishes a command, and in a tail step
  // that finds a new piece while an older one is held.
  always_comb begin
    case (cmd.op)
      mbrm_pkg::OP_BAD,
      mbrm_pkg::OP_WR_NEXT,
      mbrm_pkg::OP_FIN,
      mbrm_pkg::OP_QRY,
      mbrm_pkg::OP_TAIL_END:  res_fire = 1'b1;
      mbrm_pkg::OP_WR_CHECK:  res_fire = !sts.need_adv;
      mbrm_pkg::OP_RD_STEP:   res_fire = sts.rd_done;
      mbrm_pkg::OP_TAIL_STEP: res_fire = (fill_cur != '0) && pend_valid;
      default:                res_fire = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overwrite_mode <= 1'b0;
      banks_in_use   <= RW'(4);
      bank_capacity  <= LW'(mbrm_pkg::BANK_BYTES);
      for (int i = 0; i < mbrm_pkg::NUM_BANKS; i++) begin
        fill_level[i] <= '0;
        bank_full[i]  <= 1'b0;
      end
      write_bank   <= '0;
      read_bank    <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_fire;

      if (cfg_valid) begin
        case (cfg_index)
          mbrm_pkg::CFG_OVERWRITE: overwrite_mode <= cfg_data[0];
          mbrm_pkg::CFG_BANKS:     banks_in_use   <= cfg_data[RW-1:0];
          mbrm_pkg::CFG_CAPACITY:  bank_capacity  <= cfg_data;
          default: ;
        endcase
      end

      case (cmd.op)
        mbrm_pkg::OP_LOAD_WR: begin
          ptr        <= wb_red;
          write_bank <= wb_red;
          chunk_len  <= item.chunk_length;
        end
        mbrm_pkg::OP_LOAD_RD: begin
          ptr       <= rb_red;
          read_bank <= rb_red;
          cnt       <= '0;
        end
        mbrm_pkg::OP_LOAD_FIN: begin
          ptr <= item.bank_select;
        end
        mbrm_pkg::OP_LOAD_QRY: begin
          ptr        <= wb_red;
          write_bank <= wb_red;
        end
        mbrm_pkg::OP_LOAD_TAIL: begin
          ptr        <= wb_red;
          cnt        <= '0;
          want       <= item.tail_size;
          pend_valid <= 1'b0;
        end
        mbrm_pkg::OP_BAD: begin
          result <= make_res(mbrm_pkg::ST_NOTHING, '0, '0, '0, 1'b1);
        end
        mbrm_pkg::OP_WR_CHECK: begin
          if (too_long) begin
            result <= make_res(mbrm_pkg::ST_TOO_LONG, '0, '0, '0, 1'b1);
          end else if (!overwrite_mode && full_cur) begin
            result <= make_res(mbrm_pkg::ST_NO_FREE, '0, '0, '0, 1'b1);
          end else if (fits) begin
            fill_level[ptr] <= sum[LW-1:0];
            result          <= make_res(mbrm_pkg::ST_OK, ptr, fill_cur, sum[LW-1:0], 1'b1);
          end else begin
            // The current bank cannot take the chunk: move the ring on.
            if (!overwrite_mode) begin
              bank_full[ptr] <= 1'b1;
            end
            ptr        <= ptr_next;
            write_bank <= ptr_next;
          end
        end
        mbrm_pkg::OP_WR_NEXT: begin
          if (overwrite_mode) begin
            fill_level[ptr] <= chunk_len;
            result          <= make_res(mbrm_pkg::ST_OK, ptr, '0, chunk_len, 1'b1);
          end else if (full_cur || !fits) begin
            result <= make_res(mbrm_pkg::ST_NO_FREE, '0, '0, '0, 1'b1);
          end else begin
            fill_level[ptr] <= sum[LW-1:0];
            result          <= make_res(mbrm_pkg::ST_OK, ptr, fill_cur, sum[LW-1:0], 1'b1);
          end
        end
        mbrm_pkg::OP_RD_STEP: begin
          if (full_cur) begin
            read_bank <= ptr;
            result    <= make_res(mbrm_pkg::ST_OK, ptr, '0, fill_cur, 1'b1);
          end else begin
            ptr <= ptr_next;
            cnt <= cnt + BW'(1);
            if (cnt_last) begin
              result <= make_res(mbrm_pkg::ST_NOTHING, '0, '0, '0, 1'b1);
            end
          end
        end
        mbrm_pkg::OP_FIN: begin
          if ({1'b0, ptr} >= ring_n) begin
            result <= make_res(mbrm_pkg::ST_NOTHING, '0, '0, '0, 1'b1);
          end else begin
            fill_level[ptr] <= '0;
            bank_full[ptr]  <= 1'b0;
            read_bank       <= ptr_next;
            result          <= make_res(mbrm_pkg::ST_OK, ptr, '0, '0, 1'b1);
          end
        end
        mbrm_pkg::OP_QRY: begin
          if (full_cur) begin
            result <= make_res(mbrm_pkg::ST_NO_FREE, ptr, '0, '0, 1'b1);
          end else begin
            result <= make_res(mbrm_pkg::ST_OK, ptr, '0, fill_cur, 1'b1);
          end
        end
        mbrm_pkg::OP_TAIL_STEP: begin
          // A found piece is held until the next is found, so the final one can carry last.
          if (fill_cur != '0) begin
            if (pend_valid) begin
              result <= pend;
            end
            pend       <= make_res(mbrm_pkg::ST_OK, ptr, fill_cur - take, take, 1'b0);
            pend_valid <= 1'b1;
          end
          want <= want_after;
          ptr  <= ptr_prev;
          cnt  <= cnt + BW'(1);
        end
        mbrm_pkg::OP_TAIL_END: begin
          if (pend_valid) begin
            result <= make_res(pend.status, pend.bank, pend.offset, pend.length_out, 1'b1);
          end else begin
            result <= make_res(mbrm_pkg::ST_NOTHING, '0, '0, '0, 1'b1);
          end
          pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/multi_bank_buffer_ring_manager.sv
// Top level of the multi-bank buffer ring manager: joins mbrm_ctrl and mbrm_dp.
// Depends on mbrm_pkg, mbrm_ctrl and mbrm_dp.
//
// Channel      Ports                                   Transaction when
// command      start, busy, item                       start && !busy
// result       result_valid, result                    result_valid (one cycle)
// config       cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid && cfg_ready
//
// Each command is handled alone; every bank lookup goes through one access
// pointer, one bank per cycle. After acceptance busy stays high through the
// controller states: write check, then write next if the chunk must go to the next bank;
// a read scan until a full bank or the whole ring; finish or query; tail steps
// then tail end. An unknown command does not raise busy. Results follow one
// per cycle at most and cannot be stalled. Reset is synchronous; config is always ready.
`timescale 1ns / 1ps
`default_nettype none

module multi_bank_buffer_ring_manager (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire mbrm_pkg::in_item_t            item,
  output mbrm_pkg::result_t                  result,
  output logic                               result_valid,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [mbrm_pkg::LEVEL_W-1:0]  cfg_data
);

  mbrm_pkg::dp_cmd_t    cmd;
  mbrm_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  mbrm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  mbrm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire
